>>> hdl/partition_fit_allocator_macros.svh
// ----------------------------------------------------------------------------
// partition_fit_allocator_macros
// assertion macros used by the checker file pfa_checker
// ----------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the partition fit allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int AMOUNT_W   = 16;
    localparam int INDEX_W    = 4;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_mode_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b1;

    typedef struct packed {
        logic valid;
        logic found;
        logic hi_found;
    } tok_flags_t;

endpackage

>>> hdl/pfa_cell.sv
// ----------------------------------------------------------------------------
// pfa_cell
// one partition: holds its capacity and updates the passing search token
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfa_cell #(
    parameter int CELL_INDEX = 0,
    parameter int PARTITIONS = pfa_pkg::PARTITIONS_DEF,
    parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF,
    localparam int IDX_W     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
    localparam int CNT_W     = $clog2(PARTITIONS + 1),
    localparam int WIDX_W    = (IDX_W > pfa_pkg::INDEX_W) ? IDX_W : pfa_pkg::INDEX_W,
    localparam int CMP_W     = (SIZE_BITS > pfa_pkg::AMOUNT_W) ? SIZE_BITS : pfa_pkg::AMOUNT_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pfa_pkg::fit_mode_t              fit_mode,
    input  logic [CNT_W-1:0]                count_in_use,
    input  logic [IDX_W-1:0]                next_ptr,
    input  logic                            wr_en,
    input  logic [WIDX_W-1:0]               wr_index,
    input  logic [SIZE_BITS-1:0]            wr_value,
    input  pfa_pkg::tok_flags_t             flags_in,
    input  logic [pfa_pkg::AMOUNT_W-1:0]    amount_in,
    input  logic [IDX_W-1:0]                best_index_in,
    input  logic [SIZE_BITS-1:0]            best_cap_in,
    input  logic [IDX_W-1:0]                hi_index_in,
    input  logic [SIZE_BITS-1:0]            hi_cap_in,
    output pfa_pkg::tok_flags_t             flags_out,
    output logic [pfa_pkg::AMOUNT_W-1:0]    amount_out,
    output logic [IDX_W-1:0]                best_index_out,
    output logic [SIZE_BITS-1:0]            best_cap_out,
    output logic [IDX_W-1:0]                hi_index_out,
    output logic [SIZE_BITS-1:0]            hi_cap_out
);

    logic [SIZE_BITS-1:0]         cap_reg, cap_next;
    pfa_pkg::tok_flags_t          flags_reg, flags_next;
    logic [pfa_pkg::AMOUNT_W-1:0] amount_reg;
    logic [IDX_W-1:0]             best_index_reg, best_index_next;
    logic [SIZE_BITS-1:0]         best_cap_reg, best_cap_next;
    logic [IDX_W-1:0]             hi_index_reg, hi_index_next;
    logic [SIZE_BITS-1:0]         hi_cap_reg, hi_cap_next;

    logic in_use;
    logic fits;
    logic beyond_ptr;
    logic better;
    logic take_best;
    logic take_hi;

    assign in_use     = CNT_W'(CELL_INDEX) < count_in_use;
    assign fits       = in_use && (CMP_W'(cap_reg) >= CMP_W'(amount_in));
    assign beyond_ptr = IDX_W'(CELL_INDEX) >= next_ptr;

    always_comb
    begin
        unique case (fit_mode)
            pfa_pkg::FIT_FIRST: better = 1'b0;
            pfa_pkg::FIT_BEST:  better = cap_reg < best_cap_in;
            pfa_pkg::FIT_WORST: better = cap_reg > best_cap_in;
            pfa_pkg::FIT_NEXT:  better = 1'b0;
            default:            better = 1'b0;
        endcase
    end

    assign take_best = fits && (!flags_in.found || better);
    assign take_hi   = fits && beyond_ptr && !flags_in.hi_found;

    always_comb
    begin
        cap_next = cap_reg;
        if (wr_en && (wr_index == WIDX_W'(CELL_INDEX)))
        begin
            cap_next = wr_value;
        end
    end

    always_comb
    begin
        flags_next          = flags_reg;
        flags_next.valid    = flags_in.valid;
        best_index_next     = best_index_in;
        best_cap_next       = best_cap_in;
        hi_index_next       = hi_index_in;
        hi_cap_next         = hi_cap_in;
        if (flags_in.valid)
        begin
            flags_next.found    = flags_in.found | take_best;
            flags_next.hi_found = flags_in.hi_found | take_hi;
        end
        if (take_best)
        begin
            best_index_next = IDX_W'(CELL_INDEX);
            best_cap_next   = cap_reg;
        end
        if (take_hi)
        begin
            hi_index_next = IDX_W'(CELL_INDEX);
            hi_cap_next   = cap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= '0;
            flags_reg <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flags_in.valid)
        begin
            amount_reg     <= amount_in;
            best_index_reg <= best_index_next;
            best_cap_reg   <= best_cap_next;
            hi_index_reg   <= hi_index_next;
            hi_cap_reg     <= hi_cap_next;
        end
    end

    assign flags_out      = flags_reg;
    assign amount_out     = amount_reg;
    assign best_index_out = best_index_reg;
    assign best_cap_out   = best_cap_reg;
    assign hi_index_out   = hi_index_reg;
    assign hi_cap_out     = hi_cap_reg;

endmodule

>>> hdl/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// partition table with first, best, worst and next fit job placement
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_stall  | operation, partition_index, amount, last_job
// out      | out_valid / out_stall| assigned, chosen_partition, remaining_capacity
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a load writes its capacity when accepted and is followed by the next at once
// during an allocate transaction a search token walks the row of cells, one cell
// per cycle, then the write state writes the chosen capacity back
// reset clears every capacity and the next fit pointer and resets the control registers
// a stalled result waits in the output register; the next item is accepted
// meanwhile and its write-back waits until the result has left
`timescale 1ns / 1ps

module partition_fit_allocator #(
    parameter int PARTITIONS = pfa_pkg::PARTITIONS_DEF,
    parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [pfa_pkg::INDEX_W-1:0]       partition_index,
    input  logic [pfa_pkg::AMOUNT_W-1:0]      amount,
    input  logic                              last_job,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              assigned,
    output logic [pfa_pkg::INDEX_W-1:0]       chosen_partition,
    output logic [pfa_pkg::AMOUNT_W-1:0]      remaining_capacity,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(PARTITIONS + 1);
    localparam int WIDX_W = (IDX_W > pfa_pkg::INDEX_W) ? IDX_W : pfa_pkg::INDEX_W;
    localparam int CMP_W  = (SIZE_BITS > pfa_pkg::AMOUNT_W) ? SIZE_BITS : pfa_pkg::AMOUNT_W;
    localparam int CNTC_W = (CNT_W > pfa_pkg::COUNT_W) ? CNT_W : pfa_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    pfa_pkg::fit_mode_t              fit_mode_reg, fit_mode_next;
    logic [pfa_pkg::COUNT_W-1:0]     partition_count_reg, partition_count_next;
    logic [IDX_W-1:0]                ptr_reg, ptr_next;
    logic                            last_reg, last_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_assigned_reg, out_assigned_next;
    logic [pfa_pkg::INDEX_W-1:0]     out_chosen_reg, out_chosen_next;
    logic [pfa_pkg::AMOUNT_W-1:0]    out_remaining_reg, out_remaining_next;

    logic                            in_fire;
    logic                            is_alloc;
    logic                            out_free;
    logic [CNT_W-1:0]                count_in_use;

    logic                            wr_en;
    logic [WIDX_W-1:0]               wr_index;
    logic [SIZE_BITS-1:0]            wr_value;
    logic [CMP_W-1:0]                load_wide;

    pfa_pkg::tok_flags_t             chain_flags      [0:PARTITIONS];
    logic [pfa_pkg::AMOUNT_W-1:0]    chain_amount     [0:PARTITIONS];
    logic [IDX_W-1:0]                chain_best_index [0:PARTITIONS];
    logic [SIZE_BITS-1:0]            chain_best_cap   [0:PARTITIONS];
    logic [IDX_W-1:0]                chain_hi_index   [0:PARTITIONS];
    logic [SIZE_BITS-1:0]            chain_hi_cap     [0:PARTITIONS];

    pfa_pkg::tok_flags_t             end_flags;
    logic                            use_hi;
    logic [IDX_W-1:0]                pick_index;
    logic [SIZE_BITS-1:0]            pick_cap;
    logic [SIZE_BITS-1:0]            pick_rem;
    logic [CMP_W-1:0]                rem_wide;
    logic [WIDX_W-1:0]               pick_wide;
    logic [CNT_W-1:0]                pick_plus;

    assign in_fire   = in_valid && !in_stall;
    assign is_alloc  = pfa_pkg::op_t'(operation) == pfa_pkg::OP_ALLOC;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;

    assign count_in_use = (CNTC_W'(partition_count_reg) > CNTC_W'(PARTITIONS))
                        ? CNT_W'(PARTITIONS) : CNT_W'(partition_count_reg);

    // search token enters the first cell
    always_comb
    begin
        chain_flags[0]          = '0;
        chain_flags[0].valid    = in_fire && is_alloc;
        chain_amount[0]         = amount;
        chain_best_index[0]     = '0;
        chain_best_cap[0]       = '0;
        chain_hi_index[0]       = '0;
        chain_hi_cap[0]         = '0;
    end

    for (genvar g = 0; g < PARTITIONS; g++)
    begin : g_cell
        pfa_cell #(
            .CELL_INDEX (g),
            .PARTITIONS (PARTITIONS),
            .SIZE_BITS  (SIZE_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .fit_mode       (fit_mode_reg),
            .count_in_use   (count_in_use),
            .next_ptr       (ptr_reg),
            .wr_en          (wr_en),
            .wr_index       (wr_index),
            .wr_value       (wr_value),
            .flags_in       (chain_flags[g]),
            .amount_in      (chain_amount[g]),
            .best_index_in  (chain_best_index[g]),
            .best_cap_in    (chain_best_cap[g]),
            .hi_index_in    (chain_hi_index[g]),
            .hi_cap_in      (chain_hi_cap[g]),
            .flags_out      (chain_flags[g+1]),
            .amount_out     (chain_amount[g+1]),
            .best_index_out (chain_best_index[g+1]),
            .best_cap_out   (chain_best_cap[g+1]),
            .hi_index_out   (chain_hi_index[g+1]),
            .hi_cap_out     (chain_hi_cap[g+1])
        );
    end

    // pick from the token that left the last cell
    assign end_flags  = chain_flags[PARTITIONS];
    assign use_hi     = (fit_mode_reg == pfa_pkg::FIT_NEXT) && end_flags.hi_found;
    assign pick_index = use_hi ? chain_hi_index[PARTITIONS] : chain_best_index[PARTITIONS];
    assign pick_cap   = use_hi ? chain_hi_cap[PARTITIONS] : chain_best_cap[PARTITIONS];
    assign pick_rem   = pick_cap - SIZE_BITS'(chain_amount[PARTITIONS]);
    assign rem_wide   = CMP_W'(pick_rem);
    assign pick_wide  = WIDX_W'(pick_index);
    assign pick_plus  = CNT_W'(pick_index) + CNT_W'(1);
    assign load_wide  = CMP_W'(amount);

    always_comb
    begin
        state_next           = state_reg;
        fit_mode_next        = fit_mode_reg;
        partition_count_next = partition_count_reg;
        ptr_next             = ptr_reg;
        last_next            = last_reg;
        out_valid_next       = out_valid_reg;
        out_assigned_next    = out_assigned_reg;
        out_chosen_next      = out_chosen_reg;
        out_remaining_next   = out_remaining_reg;
        wr_en                = 1'b0;
        wr_index             = WIDX_W'(partition_index);
        wr_value             = load_wide[SIZE_BITS-1:0];

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pfa_pkg::CFG_FIT_MODE)
            begin
                fit_mode_next = pfa_pkg::fit_mode_t'(cfg_data[pfa_pkg::MODE_W-1:0]);
            end
            else if (cfg_index == pfa_pkg::CFG_PART_COUNT)
            begin
                partition_count_next = cfg_data[pfa_pkg::COUNT_W-1:0];
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_alloc)
                    begin
                        last_next  = last_job;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (last_job)
                        begin
                            ptr_next = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (end_flags.valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (end_flags.found)
                    begin
                        wr_en              = 1'b1;
                        wr_index           = pick_wide;
                        wr_value           = pick_rem;
                        out_assigned_next  = 1'b1;
                        out_chosen_next    = pick_wide[pfa_pkg::INDEX_W-1:0];
                        out_remaining_next = rem_wide[pfa_pkg::AMOUNT_W-1:0];
                        if (fit_mode_reg == pfa_pkg::FIT_NEXT)
                        begin
                            ptr_next = (pick_plus >= count_in_use) ? '0 : IDX_W'(pick_plus);
                        end
                    end
                    else
                    begin
                        out_assigned_next  = 1'b0;
                        out_chosen_next    = '0;
                        out_remaining_next = '0;
                    end
                    if (last_reg)
                    begin
                        ptr_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            fit_mode_reg        <= pfa_pkg::FIT_FIRST;
            partition_count_reg <= pfa_pkg::COUNT_W'(16);
            ptr_reg             <= '0;
            last_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            fit_mode_reg        <= fit_mode_next;
            partition_count_reg <= partition_count_next;
            ptr_reg             <= ptr_next;
            last_reg            <= last_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_assigned_reg  <= out_assigned_next;
        out_chosen_reg    <= out_chosen_next;
        out_remaining_reg <= out_remaining_next;
    end

    assign out_valid          = out_valid_reg;
    assign assigned           = out_assigned_reg;
    assign chosen_partition   = out_chosen_reg;
    assign remaining_capacity = out_remaining_reg;

endmodule

>>> hdl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// port-level checks of the partition fit allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "partition_fit_allocator_macros.svh"

module pfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           operation,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           assigned,
    input logic [pfa_pkg::INDEX_W-1:0]    chosen_partition,
    input logic [pfa_pkg::AMOUNT_W-1:0]   remaining_capacity
);

    logic load_fire;
    logic alloc_fire;

    assign load_fire  = in_valid && !in_stall && (operation == pfa_pkg::OP_LOAD);
    assign alloc_fire = in_valid && !in_stall && (operation == pfa_pkg::OP_ALLOC);

    // a load never blocks the input
    `PFA_ASSERT_NEXT(a_load_keeps_ready, load_fire, !in_stall)
    // an allocation holds off the input while it scans
    `PFA_ASSERT_NEXT(a_alloc_blocks_input, alloc_fire, in_stall)
    // an unassigned result carries zero payload
    `PFA_ASSERT_IMPL(a_unassigned_zero, out_valid && !assigned,
                     (chosen_partition == '0) && (remaining_capacity == '0))
    // a stalled result stays offered
    `PFA_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .operation          (operation),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .assigned           (assigned),
    .chosen_partition   (chosen_partition),
    .remaining_capacity (remaining_capacity)
);
